// ----- src/solid_texture_sampler_defines.svh -----
// Assertion macros shared by the solid texture sampler RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef SOLID_TEXTURE_SAMPLER_DEFINES_SVH
`define SOLID_TEXTURE_SAMPLER_DEFINES_SVH

// Clocked property check, switched off while reset is asserted.
`define STS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A condition that must never hold at a clock edge.
`define STS_NEVER(lbl, cond, msg) `STS_ASSERT(lbl, !(cond), msg)

`endif

// ----- src/stex_pkg.sv -----
// Package for the solid texture sampler: constants, codes, types and helpers.
// Used by every module of the block; depends on nothing.
package stex_pkg;

	localparam int ADDR_W      = 18;
	localparam int TEXEL_W     = 24;
	localparam int SIZE_W      = 10;
	localparam int IDX_W       = 9;
	localparam int FRAC_BITS   = 16;
	localparam int INT_W       = 16;
	localparam int MAX_EXTENT  = 512;
	localparam int PIPE_DEPTH  = 19;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [2:0] REG_WIDTH   = 3'd0;
	localparam logic [2:0] REG_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_DEPTH   = 3'd2;
	localparam logic [2:0] REG_MODE    = 3'd3;
	localparam logic [2:0] REG_PRESENT = 3'd4;
	localparam logic [2:0] REG_BOX_X   = 3'd5;
	localparam logic [2:0] REG_BOX_Y   = 3'd6;
	localparam logic [2:0] REG_BOX_Z   = 3'd7;

	localparam logic [TEXEL_W-1:0] MAGENTA = 24'hFF00FF;

	// Control and write payload that travels beside the index units.
	typedef struct packed {
		logic               valid;
		logic               cmd;
		logic               no_tex;
		logic [ADDR_W-1:0]  widx;
		logic [TEXEL_W-1:0] wdata;
	} item_meta_t;

	// Saturate an axis size register to the range one to MAX_EXTENT.
	function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] r);
		logic [SIZE_W-1:0] s;
		if (r == '0)
			s = SIZE_W'(1);
		else if (r > SIZE_W'(MAX_EXTENT))
			s = SIZE_W'(MAX_EXTENT);
		else
			s = r;
		return s;
	endfunction

endpackage

// ----- src/stex_axis.sv -----
// One axis of the coordinate-to-index mapping: brick modulo or bounded scaling.
// A pipelined restoring divider, one quotient bit a stage. Uses stex_pkg.
module stex_axis (
	input  logic                         clk,
	input  logic                         adv,
	input  logic signed [31:0]           coord,
	input  logic                         mode,
	input  logic [stex_pkg::SIZE_W-1:0]  size,
	input  logic [63:0]                  box,
	output logic [stex_pkg::IDX_W-1:0]   index
);
	import stex_pkg::*;

	localparam int STEPS = INT_W;

	logic [32:0] cx, mag;
	logic signed [33:0] num_c, den_c;
	logic zero_c, sat_c;

	logic [INT_W-1:0] int_s1;
	logic [31:0] num_s1;
	logic [32:0] den_s1;
	logic zero_s1, sat_s1;

	logic [41:0] prod;

	logic [33:0] div_r   [0:STEPS];
	logic [INT_W-1:0] div_low [0:STEPS];
	logic [INT_W-1:0] div_q   [0:STEPS];
	logic [32:0] div_dvs [0:STEPS];
	logic        div_zero [0:STEPS];
	logic        div_sat  [0:STEPS];

	logic [IDX_W-1:0] index_q;

	always_comb begin
		cx = {coord[31], coord};
		mag = coord[31] ? (33'd0 - cx) : cx;
		num_c = {{2{coord[31]}}, coord} - {{2{box[31]}}, box[31:0]};
		den_c = {{2{box[63]}}, box[63:32]} - {{2{box[31]}}, box[31:0]}
			+ 34'(1 << FRAC_BITS);
		zero_c = den_c[33] || (den_c == '0) || num_c[33] || (num_c == '0);
		sat_c = !zero_c && (num_c[32:0] >= den_c[32:0]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			int_s1 <= mag[31:16];
			num_s1 <= num_c[31:0];
			den_s1 <= den_c[32:0];
			zero_s1 <= zero_c;
			sat_s1 <= sat_c;
		end
	end

	assign prod = num_s1 * size;

	// Bounded mode: the quotient is known to be below 2^16, so the upper
	// product bits seed the remainder and only the low 16 bits are shifted in.
	always_ff @(posedge clk) begin
		if (adv) begin
			div_r[0]    <= mode ? {8'd0, prod[41:16]} : 34'd0;
			div_low[0]  <= mode ? prod[15:0] : int_s1;
			div_dvs[0]  <= mode ? den_s1 : {23'd0, size};
			div_q[0]    <= '0;
			div_zero[0] <= mode && zero_s1;
			div_sat[0]  <= mode && sat_s1;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_div
		logic [33:0] r2, rn;
		logic ge;
		always_comb begin
			r2 = {div_r[k][32:0], div_low[k][INT_W-1]};
			ge = r2 >= {1'b0, div_dvs[k]};
			rn = ge ? (r2 - {1'b0, div_dvs[k]}) : r2;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				div_r[k+1]    <= rn;
				div_low[k+1]  <= {div_low[k][INT_W-2:0], 1'b0};
				div_q[k+1]    <= {div_q[k][INT_W-2:0], ge};
				div_dvs[k+1]  <= div_dvs[k];
				div_zero[k+1] <= div_zero[k];
				div_sat[k+1]  <= div_sat[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (div_zero[STEPS])
				index_q <= '0;
			else if (!mode)
				index_q <= div_r[STEPS][IDX_W-1:0];
			else if (div_sat[STEPS])
				index_q <= IDX_W'(size - SIZE_W'(1));
			else
				index_q <= div_q[STEPS][IDX_W-1:0];
		end
	end

	assign index = index_q;

endmodule

// ----- src/stex_store.sv -----
// Texel address generation and the texel memory with its output register.
// Uses stex_pkg; writes and reads reach the memory in item order.
module stex_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  stex_pkg::item_meta_t          meta,
	input  logic [stex_pkg::IDX_W-1:0]    ix,
	input  logic [stex_pkg::IDX_W-1:0]    iy,
	input  logic [stex_pkg::IDX_W-1:0]    iz,
	input  logic [stex_pkg::SIZE_W-1:0]   width,
	input  logic [stex_pkg::SIZE_W-1:0]   height,
	output logic                          out_valid,
	output logic                          out_no_tex,
	output logic [stex_pkg::TEXEL_W-1:0]  out_texel
);
	import stex_pkg::*;

	logic [TEXEL_W-1:0] mem [0:(1 << ADDR_W)-1];

	item_meta_t meta_s1, meta_s2;
	logic [ADDR_W-1:0] row_s1, addr_s2;
	logic [IDX_W-1:0] ix_s1;
	logic [18:0] row_prod;
	logic [27:0] addr_prod;
	logic [TEXEL_W-1:0] rd_q;
	logic valid_q, no_tex_q;

	assign row_prod = iz * height;
	assign addr_prod = row_s1 * width;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1.valid <= 1'b0;
			meta_s2.valid <= 1'b0;
			valid_q <= 1'b0;
		end else if (adv) begin
			meta_s1 <= meta;
			meta_s2 <= meta_s1;
			valid_q <= meta_s2.valid && (meta_s2.cmd == CMD_LOOKUP);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_s1 <= ADDR_W'(row_prod) + ADDR_W'(iy);
			ix_s1 <= ix;
			addr_s2 <= addr_prod[ADDR_W-1:0] + ADDR_W'(ix_s1);
			no_tex_q <= meta_s2.no_tex;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && meta_s2.valid && (meta_s2.cmd == CMD_WRITE))
			mem[meta_s2.widx] <= meta_s2.wdata;
	end

	always_ff @(posedge clk) begin
		if (adv)
			rd_q <= mem[addr_s2];
	end

	assign out_valid = valid_q;
	assign out_no_tex = no_tex_q;
	assign out_texel = no_tex_q ? MAGENTA : rd_q;

endmodule

// ----- src/solid_texture_sampler.sv -----
// Solid texture sampler: 3-D RGB texel store with brick or bounded lookup.
// A lookup item passes the three axis units, address generation and the registered memory read.
// Throughput: one item per cycle; the whole pipeline stalls only while a
// finished result waits at the output. Writes produce no result item.
// Reset (arst_n low, asynchronous) clears pipeline valids and the registers
// to width 512, height 512, depth 1, brick mode, no texture, zero boxes.
module solid_texture_sampler (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [63:0]   cfg_data,
	input  logic          s_tvalid,
	output logic          s_tready,
	// hit_x, hit_y, hit_z, texel_index, texel_red, texel_green, texel_blue
	input  logic [143:0]  s_tdata,
	// command
	input  logic          s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// red, green, blue
	output logic [23:0]   m_tdata,
	// no_texture
	output logic          m_tuser
);
	import stex_pkg::*;

	`include "solid_texture_sampler_defines.svh"

	// Configuration registers. The user must change them only while no item is in flight;
	// the block does not enforce this, and every stage reads them directly.
	logic [SIZE_W-1:0] width_q, height_q;
	logic [6:0] depth_q;
	logic mode_q, present_q;
	logic [63:0] box_x_q, box_y_q, box_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= SIZE_W'(512);
			height_q <= SIZE_W'(512);
			depth_q <= 7'd1;
			mode_q <= 1'b0;
			present_q <= 1'b0;
			box_x_q <= '0;
			box_y_q <= '0;
			box_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:   width_q <= cfg_data[SIZE_W-1:0];
				REG_HEIGHT:  height_q <= cfg_data[SIZE_W-1:0];
				REG_DEPTH:   depth_q <= cfg_data[6:0];
				REG_MODE:    mode_q <= cfg_data[0];
				REG_PRESENT: present_q <= cfg_data[0];
				REG_BOX_X:   box_x_q <= cfg_data;
				REG_BOX_Y:   box_y_q <= cfg_data;
				REG_BOX_Z:   box_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [SIZE_W-1:0] size_w, size_h, size_d;
	assign size_w = sat_size(width_q);
	assign size_h = sat_size(height_q);
	assign size_d = sat_size({3'd0, depth_q});

	// The pipeline moves as one; it holds while the output item is not taken.
	logic adv;
	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;

	// Item control and write payload travel beside the three axis units.
	item_meta_t meta_in;
	item_meta_t meta_q [0:PIPE_DEPTH-1];

	always_comb begin
		meta_in.valid = s_tvalid;
		meta_in.cmd = s_tuser;
		meta_in.no_tex = !present_q;
		meta_in.widx = s_tdata[113:96];
		meta_in.wdata = {s_tdata[121:114], s_tdata[129:122], s_tdata[137:130]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_DEPTH; i++)
				meta_q[i].valid <= 1'b0;
		end else if (adv) begin
			meta_q[0] <= meta_in;
			for (int i = 1; i < PIPE_DEPTH; i++)
				meta_q[i] <= meta_q[i-1];
		end
	end

	logic [IDX_W-1:0] ix, iy, iz;

	stex_axis u_axis_x (
		.clk(clk), .adv(adv), .coord(s_tdata[31:0]), .mode(mode_q),
		.size(size_w), .box(box_x_q), .index(ix)
	);
	stex_axis u_axis_y (
		.clk(clk), .adv(adv), .coord(s_tdata[63:32]), .mode(mode_q),
		.size(size_h), .box(box_y_q), .index(iy)
	);
	stex_axis u_axis_z (
		.clk(clk), .adv(adv), .coord(s_tdata[95:64]), .mode(mode_q),
		.size(size_d), .box(box_z_q), .index(iz)
	);

	// Address generation and the texel memory, with a write address and a read address. Writes and reads
	// reach the memory in item order, so no forwarding is needed.
	logic [TEXEL_W-1:0] texel;

	stex_store u_store (
		.clk(clk), .arst_n(arst_n), .adv(adv), .meta(meta_q[PIPE_DEPTH-1]),
		.ix(ix), .iy(iy), .iz(iz), .width(size_w), .height(size_h),
		.out_valid(m_tvalid), .out_no_tex(m_tuser), .out_texel(texel)
	);

	// The store keeps red in the top byte; red leaves in the lowest byte.
	assign m_tdata = {texel[7:0], texel[15:8], texel[23:16]};

	`STS_ASSERT(a_magenta, m_tvalid && m_tuser |-> m_tdata == MAGENTA, "no-texture item not magenta")
	`STS_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "waiting result item changed")
	`STS_NEVER(a_stall, s_tready && m_tvalid && !m_tready, "input taken during output stall")

endmodule
